[hdl/swm_pkg.sv]
// swm_pkg: shared widths, reset value and control struct for the sliding window median
// used by the top level, the sorted window and the port checker; no dependencies

package swm_pkg;

  localparam int unsigned CFG_WIDTH         = 7;
  localparam int unsigned MEDIAN_WIDTH      = 32;
  localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

  // control from the handshake logic to the sorted window
  typedef struct packed {
    logic update;  // take the sample at the port into the window
    logic flush;   // empty the window, window size was rewritten
  } swm_ctrl_t;

endpackage

[hdl/swm_window.sv]
// swm_window: the sorted window of samples with age tags, one update per cycle
// depends on swm_pkg (swm_ctrl_t)

module swm_window import swm_pkg::*; #(
  parameter int unsigned MAX_WINDOW   = 64,
  parameter int unsigned SAMPLE_WIDTH = 32,
  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int unsigned FW = $clog2(MAX_WINDOW + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swm_ctrl_t                      ctrl_i,
  input  logic [FW-1:0]                  k_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           emit_o,
  output logic signed [SAMPLE_WIDTH-1:0] median_o
);

  logic signed [SAMPLE_WIDTH-1:0] val_q [MAX_WINDOW];
  logic        [AW-1:0]           age_q [MAX_WINDOW];
  logic        [FW-1:0]           fill_q, fill_d;

  logic signed [SAMPLE_WIDTH-1:0] c_val [MAX_WINDOW];
  logic        [AW-1:0]           c_age [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] val_d [MAX_WINDOW];
  logic        [AW-1:0]           age_d [MAX_WINDOW];
  logic        [MAX_WINDOW-1:0]   rm, shift_up, ge;
  logic                           full;
  logic        [AW-1:0]           oldest;
  logic        [FW-1:0]           c_fill;
  logic        [AW-1:0]           mid;

  assign full   = (fill_q == k_i);
  assign oldest = AW'(k_i - FW'(1));
  assign c_fill = fill_q - FW'(full);
  assign emit_o = (FW'(c_fill + FW'(1)) == k_i);
  assign mid    = AW'((k_i - FW'(1)) >> 1);

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      rm[i] = full && (FW'(i) < fill_q) && (age_q[i] == oldest);
    end
    // entries at and above the evicted one move down by one place
    for (int i = 0; i < MAX_WINDOW; i++) begin
      shift_up[i] = |(rm & ({MAX_WINDOW{1'b1}} >> (MAX_WINDOW - 1 - i)));
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (shift_up[i] && (i < MAX_WINDOW - 1)) begin
        c_val[i] = val_q[(i < MAX_WINDOW - 1) ? i + 1 : i];
        c_age[i] = age_q[(i < MAX_WINDOW - 1) ? i + 1 : i];
      end else begin
        c_val[i] = val_q[i];
        c_age[i] = age_q[i];
      end
    end
    // insertion point: first free place or first entry strictly greater
    for (int i = 0; i < MAX_WINDOW; i++) begin
      ge[i] = !(FW'(i) < c_fill) || (c_val[i] > sample_i);
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (!ge[i]) begin
        val_d[i] = c_val[i];
        age_d[i] = c_age[i] + AW'(1);
      end else if ((i == 0) || !ge[(i == 0) ? 0 : i - 1]) begin
        val_d[i] = sample_i;
        age_d[i] = '0;
      end else begin
        val_d[i] = c_val[(i == 0) ? 0 : i - 1];
        age_d[i] = c_age[(i == 0) ? 0 : i - 1] + AW'(1);
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.flush) begin
      fill_d = '0;
    end else if (ctrl_i.update) begin
      fill_d = FW'(c_fill + FW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        val_q[i] <= val_d[i];
        age_q[i] <= age_d[i];
      end
    end
  end

  assign median_o = val_q[mid];

endmodule

[hdl/sliding_window_median.sv]
// sliding_window_median: lower median over the last window_size samples of a stream
// depends on swm_pkg and swm_window
//
//   channel   | handshake                        | payload
//   ----------+----------------------------------+-----------------------------
//   sample in | sample_valid_i / sample_ready_o  | sample_i  (signed)
//   median out| median_valid_o / median_ready_i  | median_o  (signed, 32 bits)
//   config    | cfg_we_i                         | cfg_wdata_i (window size)
//
// one sample per cycle unless stalled; its median is offered from the output register
// the sorted window is updated in the same edge as the sample transfer
// samples while the window is filling give no median; a config write empties it
// reset clears the window fill count and the output valid; window size resets to 3
// a stalled output holds one median in the window stage, the next sample waits

module sliding_window_median import swm_pkg::*; #(
  parameter int unsigned MAX_WINDOW   = 64,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_WIDTH-1:0]           cfg_wdata_i,
  input  logic                           sample_valid_i,
  output logic                           sample_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           median_valid_o,
  input  logic                           median_ready_i,
  output logic signed [MEDIAN_WIDTH-1:0] median_o
);

  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);

  logic [CFG_WIDTH-1:0]           ws_q;
  logic [FW-1:0]                  k;
  logic                           pend_q, pend_d;
  logic                           out_valid_q, out_valid_d;
  logic signed [MEDIAN_WIDTH-1:0] out_q;
  logic                           out_free, accept, move, emit;
  logic signed [SAMPLE_WIDTH-1:0] win_median;
  logic [MEDIAN_WIDTH+SAMPLE_WIDTH-1:0] med_ext;
  swm_ctrl_t                      ctrl;

  // effective window length, clamped to 1..MAX_WINDOW
  always_comb begin
    if (ws_q == '0) begin
      k = FW'(1);
    end else if (int'(ws_q) > int'(MAX_WINDOW)) begin
      k = FW'(MAX_WINDOW);
    end else begin
      k = FW'(ws_q);
    end
  end

  // output register free this cycle, either empty or being taken
  assign out_free       = !out_valid_q || median_ready_i;
  // window may change only once its pending median has moved on
  assign sample_ready_o = !pend_q || out_free;
  assign accept         = sample_valid_i && sample_ready_o;
  assign move           = pend_q && out_free;

  assign ctrl.update = accept;
  assign ctrl.flush  = cfg_we_i;

  swm_window #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .k_i      (k),
    .sample_i (sample_i),
    .emit_o   (emit),
    .median_o (win_median)
  );

  // median bits are taken as stored, zero padded for narrow samples
  assign med_ext = {{MEDIAN_WIDTH{1'b0}}, win_median};

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = emit;
    end else if (move) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (median_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= WINDOW_SIZE_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ws_q <= cfg_wdata_i;
      end
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= med_ext[MEDIAN_WIDTH-1:0];
    end
  end

  assign median_valid_o = out_valid_q;
  assign median_o       = out_q;

endmodule

[hdl/swm_checker.sv]
// swm_checker: port-level checks for sliding_window_median, with its bind statement
// depends on swm_pkg (CFG_WIDTH, MEDIAN_WIDTH)

module swm_checker import swm_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [CFG_WIDTH-1:0]           cfg_wdata_i,
  input logic                           sample_valid_i,
  input logic                           sample_ready_o,
  input logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input logic                           median_valid_o,
  input logic                           median_ready_i,
  input logic signed [MEDIAN_WIDTH-1:0] median_o
);

  // a median stays offered until its transfer
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    median_valid_o && !median_ready_i |=> median_valid_o)
    else $error("median valid dropped before transfer");

  // a stalled median keeps its value
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    median_valid_o && !median_ready_i |=> $stable(median_o))
    else $error("median changed while stalled");

  // an empty output never blocks the sample side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !median_valid_o |-> sample_ready_o)
    else $error("sample side stalled with empty output");

  // a fresh median comes from a sample transfer that passed the window stage and the output register
  a_median_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(median_valid_o) |-> $past(sample_valid_i && sample_ready_o, 2))
    else $error("median offered without a matching sample transfer");

endmodule

bind sliding_window_median swm_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_swm_checker (.*);
